### hw/rtl/srpc_pkg.sv
// Package for the separator run pause classifier.
// Holds the payload structs, the run record type, constants and the helper functions.
// No dependencies.
`default_nettype none

package srpc_pkg;

	// Pause kind codes.
	localparam logic [2:0] KIND_SPACE    = 3'd0;
	localparam logic [2:0] KIND_COMMA    = 3'd1;
	localparam logic [2:0] KIND_CLAUSE   = 3'd2;
	localparam logic [2:0] KIND_PERIOD   = 3'd3;
	localparam logic [2:0] KIND_QUESTION = 3'd4;
	localparam logic [2:0] KIND_EXCLAIM  = 3'd5;
	localparam logic [2:0] KIND_NEWLINE  = 3'd6;

	// Bit positions in the seen-flag vector.
	localparam int FLG_NL  = 0;
	localparam int FLG_Q   = 1;
	localparam int FLG_EXC = 2;
	localparam int FLG_PER = 3;
	localparam int FLG_CLS = 4;
	localparam int FLG_COM = 5;
	localparam int FLAG_W  = 6;

	// Strength multiplier constants in Q16.
	localparam logic [31:0] MUL_ONE  = 32'd65536;
	localparam logic [31:0] MUL_STEP = 32'd9830;
	localparam logic [31:0] MUL_MAX  = 32'd131072;
	localparam logic [31:0] MUL_HALF = 32'd32768;
	localparam logic [7:0]  CNT_MAX  = 8'd255;
	localparam logic [2:0]  BIN_MAX  = 3'd4;

	// Default depth of the run record queue.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Byte codes.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EXC   = 8'h21;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUEST = 8'h3F;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [2:0] pause_kind;
		logic [7:0] run_strength;
		logic [2:0] strength_bin;
	} out_item_t;

	// One finished run, as the front hands it to the back.
	typedef struct packed {
		logic [FLAG_W-1:0] flags;
		logic [7:0]        count;
	} run_rec_t;

	// True for C-locale whitespace and the separator punctuation.
	function automatic logic is_sep(input logic [7:0] c);
		logic ws;
		ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		return ws || c == CH_COMMA || c == CH_SEMI || c == CH_COLON ||
			c == CH_DOT || c == CH_QUEST || c == CH_EXC;
	endfunction

	// Flag that a separator byte sets; plain whitespace sets none.
	function automatic logic [FLAG_W-1:0] flag_of(input logic [7:0] c);
		logic [FLAG_W-1:0] f;
		f = '0;
		case (c)
			CH_LF, CH_CR:     f[FLG_NL]  = 1'b1;
			CH_COMMA:         f[FLG_COM] = 1'b1;
			CH_SEMI, CH_COLON: f[FLG_CLS] = 1'b1;
			CH_DOT:           f[FLG_PER] = 1'b1;
			CH_QUEST:         f[FLG_Q]   = 1'b1;
			CH_EXC:           f[FLG_EXC] = 1'b1;
			default:          f = '0;
		endcase
		return f;
	endfunction

	// Highest-priority kind among the seen flags.
	function automatic logic [2:0] kind_of(input logic [FLAG_W-1:0] f);
		logic [2:0] k;
		if (f[FLG_NL])       k = KIND_NEWLINE;
		else if (f[FLG_Q])   k = KIND_QUESTION;
		else if (f[FLG_EXC]) k = KIND_EXCLAIM;
		else if (f[FLG_PER]) k = KIND_PERIOD;
		else if (f[FLG_CLS]) k = KIND_CLAUSE;
		else if (f[FLG_COM]) k = KIND_COMMA;
		else                 k = KIND_SPACE;
		return k;
	endfunction

	// Rounded bin of the clamped multiplier 1 + 0.15*(s-1).
	function automatic logic [2:0] bin_of(input logic [7:0] s);
		logic [31:0] m;
		logic [31:0] b;
		logic [2:0]  r;
		m = MUL_ONE + ({24'd0, s} - 32'd1) * MUL_STEP;
		if (m > MUL_MAX) m = MUL_MAX;
		b = (((m - MUL_ONE) << 2) + MUL_HALF) >> 16;
		if (s <= 8'd1 || m <= MUL_ONE) r = 3'd0;
		else if (m >= MUL_MAX || b > 32'(BIN_MAX)) r = BIN_MAX;
		else r = b[2:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/srpc_front.sv
// Front end: accepts text bytes, tracks the open separator run and
// pushes one run record when the run closes. Depends on srpc_pkg.
`default_nettype none

module srpc_front import srpc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          push_valid,
	output run_rec_t      push_rec,
	input  wire logic     push_ready
);

	logic              in_run_q;
	logic [FLAG_W-1:0] flags_q;
	logic [7:0]        count_q;

	logic              sep;
	logic [FLAG_W-1:0] flags_nxt;
	logic [7:0]        count_nxt;
	logic              emit;
	logic              accept;

	// Classify the byte and form the updated run.
	always_comb begin
		sep       = is_sep(in_item.text_byte);
		flags_nxt = flags_q | flag_of(in_item.text_byte);
		count_nxt = (count_q == CNT_MAX) ? count_q : count_q + 8'd1;
		emit      = sep ? in_item.is_last : in_run_q;
		in_ready  = push_ready;
		accept    = in_valid && in_ready;
		push_valid = accept && emit;
		if (sep) begin
			push_rec.flags = flags_nxt;
			push_rec.count = count_nxt;
		end else begin
			push_rec.flags = flags_q;
			push_rec.count = count_q;
		end
	end

	// Run state; a closed run leaves the state clear for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			flags_q  <= '0;
			count_q  <= '0;
		end else if (accept) begin
			if (emit) begin
				in_run_q <= 1'b0;
				flags_q  <= '0;
				count_q  <= '0;
			end else if (sep) begin
				in_run_q <= 1'b1;
				flags_q  <= flags_nxt;
				count_q  <= count_nxt;
			end
		end
	end

`ifndef SYNTHESIS
	// An open run always holds at least one separator.
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> count_q != 8'd0)
		else $error("open run with zero count");

	// Outside a run the run state is clear.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_run_q |-> (count_q == 8'd0 && flags_q == '0))
		else $error("stale run state outside a run");

	// A final separator byte always closes its run in the same beat.
	a_last_sep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sep && in_item.is_last) |-> push_valid)
		else $error("final separator did not close the run");
`endif

endmodule

`default_nettype wire

### hw/rtl/srpc_fifo.sv
// Short queue of run records between the front and the back.
// Depends on srpc_pkg for the run record type.
`default_nettype none

module srpc_fifo import srpc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	input  wire run_rec_t push_rec,
	output logic          push_ready,
	output logic          pop_valid,
	output run_rec_t      pop_rec,
	input  wire logic     pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	run_rec_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;

	always_comb begin
		push_ready = (fill_q != CNT_FULL);
		pop_valid  = (fill_q != '0);
		pop_rec    = mem_q[rd_ptr_q];
		do_push    = push_valid && push_ready;
	end

	// Storage for queued records.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// The fill level never passes the depth.
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_FULL)
		else $error("queue overfilled");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

	// Pointers meet when the queue is empty or full.
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == CNT_FULL) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step");
`endif

endmodule

`default_nettype wire

### hw/rtl/srpc_back.sv
// Back end: turns a queued run record into kind, strength and bin,
// and holds the result in the output register. Depends on srpc_pkg.
`default_nettype none

module srpc_back import srpc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     rec_valid,
	input  wire run_rec_t rec,
	output logic          pop,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_item
);

	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t res;
	logic [7:0] strength;

	// Decode the record; a zero count still counts as one.
	always_comb begin
		strength         = (rec.count == 8'd0) ? 8'd1 : rec.count;
		res.pause_kind   = kind_of(rec.flags);
		res.run_strength = strength;
		res.strength_bin = bin_of(strength);
		pop              = rec_valid && (!out_valid_q || out_ready);
		out_valid        = out_valid_q;
		out_item         = out_item_q;
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= res;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/separator_run_pause_classifier.sv
// Separator run pause classifier: one text byte per cycle in, one result per run out.
// Throughput: one byte accepted every cycle while the run queue has room.
// The record of a closed run is written into the run queue, then loads the output
// register once that register is empty or its result is being taken.
// Reset clears the open run state, empties the queue and drops the output valid.
// Depends on srpc_pkg, srpc_front, srpc_fifo and srpc_back.
`default_nettype none

module separator_run_pause_classifier import srpc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	logic     push_valid;
	logic     push_ready;
	run_rec_t push_rec;
	logic     rec_valid;
	run_rec_t rec;
	logic     pop;

	// Byte classification and run tracking.
	srpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.push_ready (push_ready)
	);

	// Queue of finished runs.
	srpc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.push_ready (push_ready),
		.pop_valid  (rec_valid),
		.pop_rec    (rec),
		.pop        (pop)
	);

	// Result decode and output register.
	srpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for separator_run_pause_classifier: directed and random text streams.
// Predicts each run report on the fly and checks result beats in order.
// Depends on srpc_pkg and the classifier RTL.
`default_nettype none

module tb;
	import srpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;

	// Whitespace bytes that the package does not name.
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	// Every separator byte, for random picks.
	localparam logic [11:0][7:0] SEP_BYTES = {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE,
		CH_COMMA, CH_SEMI, CH_COLON, CH_DOT, CH_QUEST, CH_EXC};

	// Each separator class but question, closed by a non-separator byte,
	// ending with a run of plain whitespace other than space.
	localparam logic [19:0][7:0] KIND_WALK = {CH_SPACE, 8'h00, CH_COMMA, 8'hFF,
		CH_SEMI, 8'h80, CH_COLON, 8'h7F, CH_DOT, 8'h08, CH_EXC, 8'h0E, CH_LF, 8'h1F,
		CH_CR, 8'h22, CH_TAB, CH_VT, CH_FF, 8'h41};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	// Shadow of the open separator run.
	logic       run_open = 1'b0;
	logic [2:0] run_kind = KIND_SPACE;
	logic [7:0] run_len  = 8'd0;

	out_item_t pending_pauses [$];
	int        mismatches    = 0;
	int        quiet_cycles  = 0;
	int        items_sent    = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	separator_run_pause_classifier u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Returns whether a byte is a separator, and the kind it alone would give.
	function automatic logic classify_byte(input logic [7:0] b, output logic [2:0] k);
		case (b)
			CH_LF, CH_CR:      k = KIND_NEWLINE;
			CH_COMMA:          k = KIND_COMMA;
			CH_SEMI, CH_COLON: k = KIND_CLAUSE;
			CH_DOT:            k = KIND_PERIOD;
			CH_QUEST:          k = KIND_QUESTION;
			CH_EXC:            k = KIND_EXCLAIM;
			default:           k = KIND_SPACE;
		endcase
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR) || (k != KIND_SPACE);
	endfunction

	// Priority of a kind within a run; question outranks exclaim.
	function automatic int kind_rank(input logic [2:0] k);
		case (k)
			KIND_NEWLINE:  return 6;
			KIND_QUESTION: return 5;
			KIND_EXCLAIM:  return 4;
			KIND_PERIOD:   return 3;
			KIND_CLAUSE:   return 2;
			KIND_COMMA:    return 1;
			default:       return 0;
		endcase
	endfunction

	// Rounded quarter steps of the multiplier excess over one, saturating at one.
	function automatic logic [2:0] pause_bin(input logic [7:0] s);
		int unsigned excess;
		if (s <= 8'd1)
			return 3'd0;
		excess = (int'(s) - 1) * MUL_STEP;
		if (excess >= MUL_ONE)
			return BIN_MAX;
		return 3'((excess * 4 + MUL_HALF) / MUL_ONE);
	endfunction

	// Advances the run shadow by one byte; closes is set when a run report is due.
	function automatic void track_pause(input in_item_t it, output logic closes,
			output out_item_t res);
		logic [2:0] k;
		logic [7:0] s;
		closes = 1'b0;
		res    = '0;
		if (classify_byte(it.text_byte, k)) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_kind = KIND_SPACE;
				run_len  = 8'd0;
			end
			if (run_len != CNT_MAX)
				run_len = run_len + 8'd1;
			if (kind_rank(k) > kind_rank(run_kind))
				run_kind = k;
			closes = it.is_last;
		end else begin
			closes = run_open;
		end
		if (closes) begin
			s = (run_len == 8'd0) ? 8'd1 : run_len;
			res.pause_kind   = run_kind;
			res.run_strength = s;
			res.strength_bin = pause_bin(s);
			run_open = 1'b0;
			run_kind = KIND_SPACE;
			run_len  = 8'd0;
		end
	endfunction

	// Predict on each input beat, then check each result beat against the oldest report.
	always @(posedge clk) begin : monitor
		logic      closes;
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				track_pause(in_item, closes, want);
				if (closes)
					pending_pauses = {pending_pauses, want};
			end
			if (out_valid && out_ready) begin
				got = out_item;
				if (pending_pauses.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got kind %0d strength %0d bin %0d",
						$time, got.pause_kind, got.run_strength, got.strength_bin);
					mismatches++;
				end else begin
					want = pending_pauses.pop_front();
					if (got.pause_kind !== want.pause_kind) begin
						$display("%0t: pause_kind expected %0d got %0d",
							$time, want.pause_kind, got.pause_kind);
						mismatches++;
					end
					if (got.run_strength !== want.run_strength) begin
						$display("%0t: run_strength expected %0d got %0d",
							$time, want.run_strength, got.run_strength);
						mismatches++;
					end
					if (got.strength_bin !== want.strength_bin) begin
						$display("%0t: strength_bin expected %0d got %0d",
							$time, want.strength_bin, got.strength_bin);
						mismatches++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// The receiver stalls at random, at the current rate.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// The run ends if no beat moves on either side for too long.
	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Offers one byte after a random gap and returns at the edge that accepts it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid          = 1'b1;
		in_item.text_byte = b;
		in_item.is_last   = last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Holds the input idle until every predicted report has come out.
	task automatic drain_pauses();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pauses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One run of each separator class but question, each closed by a non-separator.
	task automatic test_separator_kinds();
		for (int i = 19; i >= 0; i--)
			send_byte(KIND_WALK[i], 1'b0);
	endtask

	// The final-byte flag on a separator, on a lone word byte, and after an open run.
	task automatic test_final_byte();
		send_byte(CH_QUEST, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(CH_DOT, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Random text: words and separator runs of mixed lengths, some texts ended
	// on either, plus bursts of raw bytes.
	task automatic test_text_stream(input int n_items);
		int         stop_at;
		int         seg_len;
		int         pick;
		logic       ends_text;
		logic [7:0] b;
		logic [2:0] k;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick      = $urandom_range(0, 99);
			ends_text = ($urandom_range(0, 9) == 0);
			if (pick < 12) begin
				seg_len = $urandom_range(1, 8);
				repeat (seg_len)
					send_byte(8'($urandom()), $urandom_range(0, 7) == 0);
			end else begin
				seg_len = $urandom_range(1, 6);
				for (int i = 0; i < seg_len; i++) begin
					do
						b = 8'($urandom());
					while (classify_byte(b, k));
					send_byte(b, ends_text && pick < 56 && i == seg_len - 1);
				end
				// Mostly short runs, with a few that saturate the count.
				pick = $urandom_range(0, 99);
				if (pick < 70)
					seg_len = $urandom_range(1, 3);
				else if (pick < 90)
					seg_len = $urandom_range(4, 10);
				else if (pick < 98)
					seg_len = $urandom_range(11, 40);
				else
					seg_len = $urandom_range(250, 300);
				for (int i = 0; i < seg_len; i++) begin
					b = ($urandom_range(0, 9) < 4) ? CH_SPACE : SEP_BYTES[$urandom_range(0, 11)];
					send_byte(b, ends_text && pick >= 50 && i == seg_len - 1);
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sender idles rarely, receiver stalls often.
		send_idle_pct = 16;
		recv_idle_pct = 87;
		test_separator_kinds();
		test_final_byte();
		test_text_stream(360);
		drain_pauses();

		// Sender idles often, receiver stalls rarely.
		send_idle_pct = 87;
		recv_idle_pct = 16;
		test_text_stream(360);
		drain_pauses();

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_text_stream(360);
		drain_pauses();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hw/rtl/srpc_pkg.sv
hw/rtl/srpc_front.sv
hw/rtl/srpc_fifo.sv
hw/rtl/srpc_back.sv
hw/rtl/separator_run_pause_classifier.sv
bench/tb.sv
